/* hw/rtl/rlpsd_pkg.sv */
// Package with the request types and constants of the RLP integer decoder.
`default_nettype none
package rlpsd_pkg;

    localparam logic [7:0] PREFIX_SHORT = 8'h80;
    localparam logic [7:0] PREFIX_LONG  = 8'hb7;
    localparam logic [7:0] PREFIX_LIST  = 8'hbf;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LIST      = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        t_status     status;
    } t_out_item;

endpackage
`default_nettype wire

/* hw/rtl/rlp_scalar_decoder.sv */
// Streaming decoder of one RLP-encoded integer, one byte per request.
//
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_data  (byte, last flag)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (value, status)
//
// The decode state updates in the cycle of acceptance.
// The result of a buffer is registered and appears in the cycle after its final byte is accepted.
// Reset returns the decoder to the prefix phase and empties the result register.
// A byte is taken while the result register is empty or being drained, so a
// stalled result holds back every byte until the result is taken.
`default_nettype none
module rlp_scalar_decoder (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire rlpsd_pkg::t_in_item i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output rlpsd_pkg::t_out_item  o_out_data
);
    import rlpsd_pkg::*;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_len_left, n_len_left;
    logic [63:0] r_pay_left, n_pay_left;
    logic [63:0] r_acc, n_acc;
    logic        r_list, n_list;
    logic        r_out_valid;
    t_out_item   r_out, n_out;
    logic        in_accept;
    logic [7:0]  b;
    logic [7:0]  len_diff;
    logic [7:0]  short_diff;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign b           = i_in_data.data_byte;
    assign len_diff    = b - PREFIX_LONG;
    assign short_diff  = b - PREFIX_SHORT;

    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_pay_left = r_pay_left;
        n_acc      = r_acc;
        n_list     = r_list;
        case (r_phase)
            PH_PREFIX: begin
                n_acc      = '0;
                n_pay_left = '0;
                n_len_left = '0;
                n_list     = 1'b0;
                if (b < PREFIX_SHORT) begin
                    n_acc   = {56'd0, b};
                    n_phase = PH_DONE;
                end else if (b <= PREFIX_LONG) begin
                    n_pay_left = {56'd0, short_diff};
                    n_phase    = (short_diff != 8'd0) ? PH_PAYLOAD : PH_DONE;
                end else if (b <= PREFIX_LIST) begin
                    n_len_left = len_diff[3:0];
                    n_phase    = PH_LENGTH;
                end else begin
                    n_list  = 1'b1;
                    n_phase = PH_DONE;
                end
            end
            PH_LENGTH: begin
                n_pay_left = {r_pay_left[55:0], b};
                if (r_len_left != 4'd0) begin
                    n_len_left = r_len_left - 4'd1;
                end
                if (r_len_left <= 4'd1) begin
                    n_phase = ({r_pay_left[55:0], b} != 64'd0) ? PH_PAYLOAD : PH_DONE;
                end
            end
            PH_PAYLOAD: begin
                n_acc = {r_acc[55:0], b};
                if (r_pay_left != 64'd0) begin
                    n_pay_left = r_pay_left - 64'd1;
                end
                if (r_pay_left <= 64'd1) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (n_phase == PH_LENGTH) begin
            n_out.value  = '0;
            n_out.status = ST_TRUNCATED;
        end else if (n_list) begin
            n_out.value  = '0;
            n_out.status = ST_LIST;
        end else begin
            n_out.value  = n_acc;
            n_out.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PREFIX;
            r_len_left  <= '0;
            r_pay_left  <= '0;
            r_acc       <= '0;
            r_list      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                if (i_in_data.last) begin
                    r_phase    <= PH_PREFIX;
                    r_len_left <= '0;
                    r_pay_left <= '0;
                    r_acc      <= '0;
                    r_list     <= 1'b0;
                end else begin
                    r_phase    <= n_phase;
                    r_len_left <= n_len_left;
                    r_pay_left <= n_pay_left;
                    r_acc      <= n_acc;
                    r_list     <= n_list;
                end
            end
            if (in_accept && i_in_data.last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in_data.last) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rlpsd_checker.sv */
// Port-level assertions for the RLP integer decoder and their bind.
`default_nettype none
module rlpsd_checker (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_valid,
    input wire                   o_in_stall,
    input wire rlpsd_pkg::t_in_item  i_in_data,
    input wire                   o_out_valid,
    input wire                   i_out_stall,
    input wire rlpsd_pkg::t_out_item o_out_data
);
    import rlpsd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result request changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.value == 64'd0)
        else $error("error result carries a nonzero value");

    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_in_data.last))
        else $error("result appeared without a final byte");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while result register is blocked");

endmodule

bind rlp_scalar_decoder rlpsd_checker u_rlpsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire
